>>> hw/rtl/carrier_sense_backoff_controller_core_defines.svh
// Assertion macros used by the checker file of the backoff controller.
`ifndef CARRIER_SENSE_BACKOFF_CONTROLLER_CORE_DEFINES_SVH
`define CARRIER_SENSE_BACKOFF_CONTROLLER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is active.
`define CSBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CSBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/csbc_pkg.sv
// Types, codes and reset constants of the carrier sense backoff controller.
package csbc_pkg;

  localparam int unsigned TimeWidthDefault = 16;

  localparam logic [15:0] MaxWaitReset       = 16'd5000;
  localparam logic [9:0]  BaseBackoffReset   = 10'd100;
  localparam logic [15:0] MaxBackoffReset    = 16'd2000;
  localparam logic [3:0]  MaxExponentReset   = 4'd4;
  localparam logic [15:0] DetectTimeoutReset = 16'd1000;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MAX_WAIT       = 3'd0,
    CFG_BASE_BACKOFF   = 3'd1,
    CFG_MAX_BACKOFF    = 3'd2,
    CFG_MAX_EXPONENT   = 3'd3,
    CFG_DETECT_TIMEOUT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_START = 2'd1,
    FN_BUSY  = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_DETECT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_GIVEUP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DETECT  = 2'd1,
    PH_BACKOFF = 2'd2
  } phase_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] rnd;
  } in_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] backoff_ms;
    logic [7:0]  fail_count;
  } out_t;

endpackage

>>> hw/rtl/carrier_sense_backoff_controller_core.sv
// Listen-before-talk controller with binary exponential backoff.
// An accepted input beat goes to the input register, and its result beat to the result register.
// One beat per cycle while out_stall_i is low; state update and backoff draw share one pass.
// Reset clears the phase, timers and failure count and loads the register defaults.
module carrier_sense_backoff_controller_core #(
  parameter int unsigned TIME_WIDTH = csbc_pkg::TimeWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  csbc_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output csbc_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [csbc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [csbc_pkg::CfgDataWidth-1:0]  cfg_wdata_i
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned CW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
  localparam logic [TW-1:0] TimeMax = '1;

  logic [15:0] max_wait_q;
  logic [9:0]  base_q;
  logic [15:0] max_backoff_q;
  logic [3:0]  max_exp_q;
  logic [15:0] detect_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wait_q    <= csbc_pkg::MaxWaitReset;
      base_q        <= csbc_pkg::BaseBackoffReset;
      max_backoff_q <= csbc_pkg::MaxBackoffReset;
      max_exp_q     <= csbc_pkg::MaxExponentReset;
      detect_to_q   <= csbc_pkg::DetectTimeoutReset;
    end else if (cfg_we_i) begin
      unique case (csbc_pkg::cfg_idx_e'(cfg_idx_i))
        csbc_pkg::CFG_MAX_WAIT:       max_wait_q    <= cfg_wdata_i;
        csbc_pkg::CFG_BASE_BACKOFF:   base_q        <= cfg_wdata_i[9:0];
        csbc_pkg::CFG_MAX_BACKOFF:    max_backoff_q <= cfg_wdata_i;
        csbc_pkg::CFG_MAX_EXPONENT:   max_exp_q     <= cfg_wdata_i[3:0];
        csbc_pkg::CFG_DETECT_TIMEOUT: detect_to_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register and result register with their handshakes.
  logic            in_vld_q;
  csbc_pkg::in_t   in_q;
  logic            out_vld_q;
  csbc_pkg::out_t  out_q;
  csbc_pkg::out_t  out_d;
  logic            adv;
  logic            go;
  logic            in_take;

  assign adv      = !out_vld_q || !out_stall_i;
  assign go       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_take  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Controller state.
  csbc_pkg::phase_e phase_q, phase_d;
  logic [TW-1:0]    elapsed_q, elapsed_d;
  logic [TW-1:0]    timer_q, timer_d;
  logic [7:0]       failures_q, failures_d;
  logic [16:0]      span_q, span_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= csbc_pkg::PH_IDLE;
      elapsed_q  <= '0;
      timer_q    <= '0;
      failures_q <= '0;
      span_q     <= 17'd1;
    end else begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      timer_q    <= timer_d;
      failures_q <= failures_d;
      span_q     <= span_d;
    end
  end

  // The random span is registered in advance from the failure count that the next beat will see.
  logic [3:0]  exp_d;
  logic [24:0] window_full;
  logic [15:0] window;

  always_comb begin
    exp_d = (failures_d > {4'd0, max_exp_q}) ? max_exp_q : failures_d[3:0];
    window_full = {15'd0, base_q} << exp_d;
    window = (window_full > {9'd0, max_backoff_q}) ? max_backoff_q : window_full[15:0];
    if (window >= {6'd0, base_q}) begin
      span_d = {1'b0, window} - {7'd0, base_q} + 17'd1;
    end else begin
      span_d = 17'd1;
    end
  end

  // Backoff draw and time clamps.
  logic [32:0]   prod;
  logic [15:0]   backoff;
  logic [TW-1:0] backoff_load;
  logic [TW-1:0] detect_load;
  logic [CW-1:0] backoff_ext;
  logic [CW-1:0] detect_ext;

  assign prod        = {17'd0, in_q.rnd} * {16'd0, span_q};
  assign backoff     = {6'd0, base_q} + prod[31:16];
  assign backoff_ext = CW'(backoff);
  assign detect_ext  = CW'(detect_to_q);
  assign backoff_load = (backoff_ext > CW'(TimeMax)) ? TimeMax : backoff_ext[TW-1:0];
  assign detect_load  = (detect_ext > CW'(TimeMax)) ? TimeMax : detect_ext[TW-1:0];

  // Event decode for the next-state and output blocks.
  logic          active;
  logic          in_detect;
  logic [TW-1:0] timer_dec;
  logic          timer_end;
  logic [TW-1:0] elapsed_inc;
  logic          wait_over;
  logic          fail_evt;
  logic          fail_tick;

  assign in_detect   = phase_q == csbc_pkg::PH_DETECT;
  assign active      = in_detect || (phase_q == csbc_pkg::PH_BACKOFF);
  assign timer_dec   = (timer_q != '0) ? timer_q - TW'(1) : '0;
  assign timer_end   = timer_dec == '0;
  assign elapsed_inc = (elapsed_q == TimeMax) ? elapsed_q : elapsed_q + TW'(1);
  assign wait_over   = (CW'(elapsed_inc) >= CW'(max_wait_q)) || (elapsed_inc == TimeMax);
  assign fail_tick   = active && timer_end && in_detect;
  assign fail_evt    = in_detect && (((in_q.func == csbc_pkg::FN_TICK) && timer_end)
                       || (in_q.func == csbc_pkg::FN_BUSY));

  always_comb begin
    phase_d    = phase_q;
    elapsed_d  = elapsed_q;
    timer_d    = timer_q;
    failures_d = failures_q;
    if (go) begin
      unique case (in_q.func)
        csbc_pkg::FN_START: begin
          elapsed_d  = '0;
          failures_d = '0;
          if (max_wait_q == '0) begin
            phase_d = csbc_pkg::PH_IDLE;
            timer_d = '0;
          end else begin
            phase_d = csbc_pkg::PH_DETECT;
            timer_d = detect_load;
          end
        end
        csbc_pkg::FN_TICK: begin
          if (active) begin
            elapsed_d = elapsed_inc;
            timer_d   = timer_dec;
            if (timer_end && !in_detect) begin
              if (wait_over) begin
                phase_d = csbc_pkg::PH_IDLE;
              end else begin
                phase_d = csbc_pkg::PH_DETECT;
                timer_d = detect_load;
              end
            end
          end
        end
        csbc_pkg::FN_CLEAR: begin
          if (in_detect) begin
            phase_d = csbc_pkg::PH_IDLE;
            timer_d = '0;
          end
        end
        csbc_pkg::FN_BUSY: ;
        default: ;
      endcase
      if (fail_evt) begin
        phase_d    = csbc_pkg::PH_BACKOFF;
        timer_d    = backoff_load;
        failures_d = (failures_q == 8'hFF) ? failures_q : failures_q + 8'd1;
      end
    end
  end

  always_comb begin
    out_d.action     = csbc_pkg::ACT_NONE;
    out_d.backoff_ms = '0;
    out_d.fail_count = failures_d;
    unique case (in_q.func)
      csbc_pkg::FN_START: begin
        out_d.action = (max_wait_q == '0) ? csbc_pkg::ACT_GIVEUP : csbc_pkg::ACT_DETECT;
      end
      csbc_pkg::FN_TICK: begin
        if (active && timer_end && !fail_tick) begin
          out_d.action = wait_over ? csbc_pkg::ACT_GIVEUP : csbc_pkg::ACT_DETECT;
        end
      end
      csbc_pkg::FN_CLEAR: begin
        if (in_detect) begin
          out_d.action = csbc_pkg::ACT_CLEAR;
        end
      end
      csbc_pkg::FN_BUSY: ;
      default: ;
    endcase
    if (fail_evt) begin
      out_d.backoff_ms = backoff;
    end
  end

endmodule

>>> hw/rtl/csbc_checker.sv
// Port-level checker for the carrier sense backoff controller and its bind.
`include "carrier_sense_backoff_controller_core_defines.svh"

module csbc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input csbc_pkg::out_t out_data_o
);

  `CSBC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result beat changed")
  `CSBC_ASSERT(a_no_stall_when_empty, !out_valid_o |-> !in_stall_o, "input stalled while result register empty")
  `CSBC_ASSERT(a_result_has_source, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2), "result beat without an input beat two cycles earlier")
  `CSBC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid right after reset")

endmodule

bind carrier_sense_backoff_controller_core csbc_checker u_csbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
